@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/rdc_pkg.sv @@
// ----------------------------------------------------------------------------
// rdc_pkg
// Types, constants and helper functions of the radix digit converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rdc_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int RADIX_W        = 5;
  localparam int DIGIT_W        = 4;
  localparam int ASCII_W        = 7;

  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(16);
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(16);

  localparam logic [ASCII_W-1:0] ASCII_ZERO   = ASCII_W'(48);
  localparam logic [ASCII_W-1:0] ASCII_LETTER = ASCII_W'(55);

  typedef struct packed {
    logic               clear;
    logic               shift;
    logic [RADIX_W-1:0] base;
  } cell_ctrl_t;

  function automatic logic [RADIX_W-1:0] clamp_radix(logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end
    return res;
  endfunction

  function automatic logic [ASCII_W-1:0] ascii_of(logic [DIGIT_W-1:0] d);
    logic [ASCII_W-1:0] res;
    if (d < DIGIT_W'(10)) begin
      res = ASCII_ZERO + ASCII_W'(d);
    end else begin
      res = ASCII_LETTER + ASCII_W'(d);
    end
    return res;
  endfunction

endpackage

@@ hdl/radix_digit_converter.sv @@
// ----------------------------------------------------------------------------
// radix_digit_converter
// Converts an unsigned binary value into its digits in a base of 2 to 16.
// ----------------------------------------------------------------------------
// Usage:
//   Write the base on the config channel (cfg_valid_i / cfg_ready_o,
//   cfg_radix_i) while the block is idle; 0 and 1 act as 2, 17..31 as 16.
//   An item is taken when start_i is high and busy_o is low.
//   Digits come out most significant first, one per cycle with strobe_o,
//   on digit_o / ascii_char_o; last_digit_o marks the final digit. Leading
//   zeros are dropped; zero gives the single digit 0.
// Operation (N = VALUE_BITS):
//   The value enters a row of N digit cells one bit per cycle; each cell
//   registers its carry to the next. The row then shifts out through the
//   top cell; leading zeros pass without a strobe. busy_o stays high while
//   the value is converted and shifted out, so no new item is taken
//   before the last one is through.
// Reset:
//   Asynchronous, active low; the base returns to 16, the block goes idle.
// The receiver cannot stall: each digit is shown for exactly one cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module radix_digit_converter #(
  parameter int VALUE_BITS = rdc_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rdc_pkg::RADIX_W-1:0]   cfg_radix_i,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [VALUE_BITS-1:0]         value_i,
  output logic                          strobe_o,
  output logic [rdc_pkg::DIGIT_W-1:0]   digit_o,
  output logic [rdc_pkg::ASCII_W-1:0]   ascii_char_o,
  output logic                          last_digit_o
);

  localparam int NCELLS = VALUE_BITS;
  localparam int CNT_W  = $clog2(VALUE_BITS + 1);
  localparam int REM_W  = $clog2(NCELLS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]                  state_q, state_d;
  logic [rdc_pkg::RADIX_W-1:0] base_q;
  logic [VALUE_BITS-1:0]       sreg_q, sreg_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic [REM_W-1:0]            rem_q, rem_d;
  logic                        seen_q, seen_d;
  logic                        accept;
  logic                        feed_done;
  logic                        conv_done;
  logic                        emit;
  logic                        strobe_q;
  logic [rdc_pkg::DIGIT_W-1:0] digit_q;
  logic [rdc_pkg::ASCII_W-1:0] ascii_q;
  logic                        last_q;
  rdc_pkg::cell_ctrl_t         ctrl;

  logic                        valid_link [0:NCELLS];
  logic                        carry_link [0:NCELLS-1];
  logic [rdc_pkg::DIGIT_W-1:0] digit_link [0:NCELLS];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= rdc_pkg::RADIX_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      base_q <= rdc_pkg::clamp_radix(cfg_radix_i);
    end
  end

  assign accept    = start_i && (state_q == ST_IDLE);
  assign feed_done = (cnt_q == CNT_W'(VALUE_BITS));
  assign conv_done = feed_done && !valid_link[NCELLS-1] && !valid_link[NCELLS];
  assign emit      = (state_q == ST_EMIT)
                   && ((digit_link[NCELLS] != '0) || seen_q || (rem_q == REM_W'(1)));

  assign ctrl.clear = accept;
  assign ctrl.shift = (state_q == ST_EMIT);
  assign ctrl.base  = base_q;

  assign valid_link[0] = (state_q == ST_CONV) && !feed_done;
  assign carry_link[0] = sreg_q[VALUE_BITS-1];
  assign digit_link[0] = '0;

  for (genvar k = 0; k < NCELLS; k++) begin : g_cell
    if (k < NCELLS - 1) begin : g_mid
      rdc_cell u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .ctrl_i      (ctrl),
        .step_valid_i(valid_link[k]),
        .carry_i     (carry_link[k]),
        .digit_i     (digit_link[k]),
        .step_valid_o(valid_link[k+1]),
        .carry_o     (carry_link[k+1]),
        .digit_o     (digit_link[k+1])
      );
    end else begin : g_top
      rdc_cell u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .ctrl_i      (ctrl),
        .step_valid_i(valid_link[k]),
        .carry_i     (carry_link[k]),
        .digit_i     (digit_link[k]),
        .step_valid_o(valid_link[k+1]),
        .carry_o     (),
        .digit_o     (digit_link[k+1])
      );
    end
  end

  always_comb begin
    state_d = state_q;
    sreg_d  = sreg_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    seen_d  = seen_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          sreg_d  = value_i;
          cnt_d   = '0;
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        if (!feed_done) begin
          sreg_d = sreg_q << 1;
          cnt_d  = cnt_q + CNT_W'(1);
        end
        if (conv_done) begin
          rem_d   = REM_W'(NCELLS);
          seen_d  = 1'b0;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        rem_d = rem_q - REM_W'(1);
        if (emit) begin
          seen_d = 1'b1;
        end
        if (rem_q == REM_W'(1)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      rem_q    <= '0;
      seen_q   <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rem_q    <= rem_d;
      seen_q   <= seen_d;
      strobe_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    sreg_q <= sreg_d;
    if (emit) begin
      digit_q <= digit_link[NCELLS];
      ascii_q <= rdc_pkg::ascii_of(digit_link[NCELLS]);
      last_q  <= (rem_q == REM_W'(1));
    end
  end

  assign busy_o       = (state_q != ST_IDLE);
  assign strobe_o     = strobe_q;
  assign digit_o      = digit_q;
  assign ascii_char_o = ascii_q;
  assign last_digit_o = last_q;

endmodule

@@ hdl/rdc_cell.sv @@
// ----------------------------------------------------------------------------
// rdc_cell
// One digit position: doubles its digit and adds the incoming carry modulo
// the base, passing the registered carry up; shifts digits up for output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rdc_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rdc_pkg::cell_ctrl_t            ctrl_i,
  input  logic                           step_valid_i,
  input  logic                           carry_i,
  input  logic [rdc_pkg::DIGIT_W-1:0]    digit_i,
  output logic                           step_valid_o,
  output logic                           carry_o,
  output logic [rdc_pkg::DIGIT_W-1:0]    digit_o
);

  logic [rdc_pkg::DIGIT_W-1:0] digit_q, digit_d;
  logic [rdc_pkg::DIGIT_W:0]   sum;
  logic                        wrap;
  logic                        valid_q;
  logic                        carry_q;

  assign sum  = {digit_q, carry_i};
  assign wrap = (sum >= ctrl_i.base);

  always_comb begin
    digit_d = digit_q;
    if (ctrl_i.clear) begin
      digit_d = '0;
    end else if (ctrl_i.shift) begin
      digit_d = digit_i;
    end else if (step_valid_i) begin
      digit_d = wrap ? rdc_pkg::DIGIT_W'(sum - ctrl_i.base) : sum[rdc_pkg::DIGIT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      carry_q <= 1'b0;
    end else begin
      valid_q <= step_valid_i && !ctrl_i.clear;
      carry_q <= step_valid_i && wrap;
    end
  end

  assign step_valid_o = valid_q;
  assign carry_o      = carry_q;
  assign digit_o      = digit_q;

endmodule

@@ hdl/rdc_checker.sv @@
// ----------------------------------------------------------------------------
// rdc_checker
// Port-level checks of the radix digit converter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rdc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start_i,
  input logic                          busy_o,
  input logic                          strobe_o,
  input logic [rdc_pkg::DIGIT_W-1:0]   digit_o,
  input logic [rdc_pkg::ASCII_W-1:0]   ascii_char_o,
  input logic                          last_digit_o
);

  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni,
               start_i && !busy_o, busy_o,
               "busy not raised after item")

  `ASSERT_NEXT(a_gap_after_last, clk_i, rst_ni,
               strobe_o && last_digit_o, !strobe_o,
               "digit right after last digit")

  `ASSERT_NEXT(a_quiet_after_accept, clk_i, rst_ni,
               start_i && !busy_o, !strobe_o,
               "digit right after accept")

  `ASSERT_IMPLIES(a_ascii_match, clk_i, rst_ni, strobe_o,
                  ((digit_o < 4'd10) && (ascii_char_o == (7'd48 + {3'b000, digit_o}))) ||
                  ((digit_o >= 4'd10) && (ascii_char_o == (7'd55 + {3'b000, digit_o}))),
                  "ascii does not match digit")

  `ASSERT_IMPLIES(a_no_lead_zero, clk_i, rst_ni,
                  strobe_o && !$past(strobe_o) && !last_digit_o, digit_o != 4'd0,
                  "leading zero emitted")

endmodule

bind radix_digit_converter rdc_checker u_rdc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .strobe_o    (strobe_o),
  .digit_o     (digit_o),
  .ascii_char_o(ascii_char_o),
  .last_digit_o(last_digit_o)
);
